// ===== rtl/core/adg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adg_pkg
// Shared constants for the Adagrad V2 element update pipeline.
// ----------------------------------------------------------------------------
package adg_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_WORD_BITS = 32;

	// register indexes on the configuration port
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_LEARNING_RATE = 2'd0;
	localparam reg_idx_t REG_EPSILON       = 2'd1;
	localparam reg_idx_t REG_UPDATE_ACC    = 2'd2;

	localparam int RST_LEARNING_RATE = 66;
	localparam int RST_EPSILON       = 1;
	localparam int RST_UPDATE_ACC    = 1;

endpackage

// ===== rtl/core/adg_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adg_sqrt_pipe
// Pipelined integer square root, one root bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module adg_sqrt_pipe #(
	parameter int VW = 48,
	parameter int SW = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [VW-1:0]           in_value,
	input  logic [SW-1:0]           in_side,
	output logic                    out_valid,
	output logic [(VW+1)/2-1:0]     out_root,
	output logic [SW-1:0]           out_side
);
	localparam int R   = (VW + 1) / 2;
	localparam int VP  = 2 * R;
	localparam int RMW = R + 3;

	logic [VP-1:0]  val_s  [R];
	logic [RMW-1:0] rem_s  [R];
	logic [R-1:0]   root_s [R];
	logic [SW-1:0]  side_s [R];
	logic           vld_s  [R];

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic [VP-1:0]  cur_val;
		logic [RMW-1:0] cur_rem;
		logic [R-1:0]   cur_root;
		logic [SW-1:0]  cur_side;
		logic           cur_vld;
		logic [RMW-1:0] rem_sh;
		logic [RMW-1:0] trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign cur_val  = VP'(in_value);
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_side = in_side;
			assign cur_vld  = in_valid;
		end else begin : g_next
			assign cur_val  = val_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_side = side_s[k-1];
			assign cur_vld  = vld_s[k-1];
		end

		// bring down two radicand bits, try root*4+1
		assign rem_sh = {cur_rem[RMW-3:0], cur_val[VP-1 -: 2]};
		assign trial  = RMW'({cur_root, 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k]  <= {cur_val[VP-3:0], 2'b00};
				rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {cur_root[R-2:0], ge};
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[R-1];
	assign out_root  = root_s[R-1];
	assign out_side  = side_s[R-1];

endmodule

// ===== rtl/core/adg_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adg_div_pipe
// Pipelined restoring divider, 2W-bit numerator by DW-bit divisor, W
// quotient bits, one bit per stage; flags a quotient that needs more bits.
// ----------------------------------------------------------------------------
module adg_div_pipe #(
	parameter int W  = 32,
	parameter int DW = 33,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [2*W-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [W-1:0]  out_quot,
	output logic          out_ovf,
	output logic [SW-1:0] out_side
);
	logic [DW-1:0] rem_s  [W];
	logic [W-1:0]  lo_s   [W];
	logic [W-1:0]  quot_s [W];
	logic [DW-1:0] den_s  [W];
	logic          ovf_s  [W];
	logic [SW-1:0] side_s [W];
	logic          vld_s  [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [DW-1:0] cur_rem;
		logic [W-1:0]  cur_lo;
		logic [W-1:0]  cur_quot;
		logic [DW-1:0] cur_den;
		logic          cur_ovf;
		logic [SW-1:0] cur_side;
		logic          cur_vld;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign cur_rem  = DW'(in_num[2*W-1:W]);
			assign cur_lo   = in_num[W-1:0];
			assign cur_quot = '0;
			assign cur_den  = in_den;
			// quotient fits in W bits only if the high half is below the divisor
			assign cur_ovf  = DW'(in_num[2*W-1:W]) >= in_den;
			assign cur_side = in_side;
			assign cur_vld  = in_valid;
		end else begin : g_next
			assign cur_rem  = rem_s[k-1];
			assign cur_lo   = lo_s[k-1];
			assign cur_quot = quot_s[k-1];
			assign cur_den  = den_s[k-1];
			assign cur_ovf  = ovf_s[k-1];
			assign cur_side = side_s[k-1];
			assign cur_vld  = vld_s[k-1];
		end

		assign t  = {cur_rem, cur_lo[W-1]};
		assign ge = t >= {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(t - {1'b0, cur_den}) : DW'(t);
				lo_s[k]   <= {cur_lo[W-2:0], 1'b0};
				quot_s[k] <= {cur_quot[W-2:0], ge};
				den_s[k]  <= cur_den;
				ovf_s[k]  <= cur_ovf;
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[W-1];
	assign out_quot  = quot_s[W-1];
	assign out_ovf   = ovf_s[W-1];
	assign out_side  = side_s[W-1];

endmodule

// ===== rtl/core/adagrad_v2_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adagrad_v2_update
// Adagrad V2 element update: acc += g^2, w -= lr*g/(sqrt(acc)+eps), with
// truncation toward zero and saturation of every result (acc update optional).
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/in_ready, gradient, weight, acc. | in
//  output   | out_valid/out_ready, new_weight, new_acc. | out
//  config   | APB psel/penable/pwrite/paddr/pwdata      | in
//
// One transfer per cycle sustained while the output is not stalled. Stages in
// order (Q16.16 by default): squaring, accumulate, one stage per root bit of
// the square root, denominator add, one stage per quotient bit of the divider,
// output. Reset clears only valid bits and sets configuration to its defaults.
// A stalled output register freezes the whole pipeline and holds in_ready low.
// ----------------------------------------------------------------------------
module adagrad_v2_update #(
	parameter int FRAC_BITS = adg_pkg::DEF_FRAC_BITS,
	parameter int WORD_BITS = adg_pkg::DEF_WORD_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [((WORD_BITS > 32) ? 3 : 2)+1:0]    paddr,
	input  logic [((WORD_BITS > 32) ? 64 : 32)-1:0]  pwdata,
	output logic [((WORD_BITS > 32) ? 64 : 32)-1:0]  prdata,
	output logic                                     pready,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [WORD_BITS-1:0]              gradient,
	input  logic signed [WORD_BITS-1:0]              weight,
	input  logic        [WORD_BITS-1:0]              accumulator,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [WORD_BITS-1:0]              new_weight,
	output logic        [WORD_BITS-1:0]              new_accumulator,
	output logic                                     saturated
);
	import adg_pkg::*;

	localparam int W      = WORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int PDW    = (W > 32) ? 64 : 32;
	localparam int ALSB   = (W > 32) ? 3 : 2;
	localparam int R      = (W + F + 1) / 2;
	localparam int DW     = W + 1;
	localparam int SQ_SW  = 4 * W + 3;
	localparam int DV_SW  = 2 * W + 3;

	// ---------------- configuration ----------------
	logic [W-1:0] lr_q;
	logic [W-1:0] eps_q;
	logic         upd_q;
	reg_idx_t     widx;
	logic         wr_en;

	assign widx   = paddr[ALSB+1:ALSB];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= W'(RST_LEARNING_RATE);
			eps_q <= W'(RST_EPSILON);
			upd_q <= 1'(RST_UPDATE_ACC);
		end else if (wr_en) begin
			unique case (widx)
				REG_LEARNING_RATE: lr_q  <= pwdata[W-1:0];
				REG_EPSILON:       eps_q <= pwdata[W-1:0];
				REG_UPDATE_ACC:    upd_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_LEARNING_RATE: prdata = PDW'(lr_q);
			REG_EPSILON:       prdata = PDW'(eps_q);
			REG_UPDATE_ACC:    prdata = PDW'(upd_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: square and numerator ----------------
	logic [W-1:0]   gmag;
	logic [2*W-1:0] sq_s1;
	logic [2*W-1:0] num_s1;
	logic           gneg_s1;
	logic [W-1:0]   w_s1;
	logic [W-1:0]   acc_s1;
	logic           vld_s1;

	assign gmag = gradient[W-1] ? W'(-gradient) : W'(gradient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= (2*W)'(gmag) * (2*W)'(gmag);
			num_s1  <= (2*W)'(lr_q) * (2*W)'(gmag);
			gneg_s1 <= gradient[W-1];
			w_s1    <= weight;
			acc_s1  <= accumulator;
		end
	end

	// ---------------- stage 2: accumulate ----------------
	logic         sq_big;
	logic [W:0]   acc_sum;
	logic [W-1:0] acc_s2;
	logic         sat_s2;
	logic [2*W-1:0] num_s2;
	logic         nz_s2;
	logic         gneg_s2;
	logic [W-1:0] w_s2;
	logic         vld_s2;

	assign sq_big  = |sq_s1[2*W-1:W+F];
	assign acc_sum = {1'b0, acc_s1} + {1'b0, sq_s1[W+F-1:F]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!upd_q) begin
				acc_s2 <= acc_s1;
				sat_s2 <= 1'b0;
			end else if (sq_big || acc_sum[W]) begin
				acc_s2 <= '1;
				sat_s2 <= 1'b1;
			end else begin
				acc_s2 <= acc_sum[W-1:0];
				sat_s2 <= 1'b0;
			end
			num_s2  <= num_s1;
			nz_s2   <= |num_s1;
			gneg_s2 <= gneg_s1;
			w_s2    <= w_s1;
		end
	end

	// ---------------- square root of acc in Q format ----------------
	logic [SQ_SW-1:0] sq_side_in;
	logic [SQ_SW-1:0] sq_side_out;
	logic             vld_rt;
	logic [R-1:0]     root;
	logic [2*W-1:0]   num_rt;
	logic             nz_rt;
	logic             gneg_rt;
	logic [W-1:0]     w_rt;
	logic [W-1:0]     acc_rt;
	logic             sat_rt;

	assign sq_side_in = {num_s2, nz_s2, gneg_s2, w_s2, acc_s2, sat_s2};
	assign {num_rt, nz_rt, gneg_rt, w_rt, acc_rt, sat_rt} = sq_side_out;

	adg_sqrt_pipe #(
		.VW (W + F),
		.SW (SQ_SW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_value  ({acc_s2, {F{1'b0}}}),
		.in_side   (sq_side_in),
		.out_valid (vld_rt),
		.out_root  (root),
		.out_side  (sq_side_out)
	);

	// ---------------- stage 3: denominator ----------------
	logic [DW-1:0]  den_s3;
	logic [2*W-1:0] num_s3;
	logic [DV_SW-1:0] dv_side_s3;
	logic           vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3     <= DW'(root) + DW'(eps_q);
			num_s3     <= num_rt;
			dv_side_s3 <= {nz_rt, gneg_rt, w_rt, acc_rt, sat_rt};
		end
	end

	// ---------------- divider ----------------
	logic [DV_SW-1:0] dv_side_out;
	logic             vld_dv;
	logic [W-1:0]     quot;
	logic             ovf;
	logic             nz_dv;
	logic             gneg_dv;
	logic [W-1:0]     w_dv;
	logic [W-1:0]     acc_dv;
	logic             sat_dv;

	assign {nz_dv, gneg_dv, w_dv, acc_dv, sat_dv} = dv_side_out;

	adg_div_pipe #(
		.W  (W),
		.DW (DW),
		.SW (DV_SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_num    (num_s3),
		.in_den    (den_s3),
		.in_side   (dv_side_s3),
		.out_valid (vld_dv),
		.out_quot  (quot),
		.out_ovf   (ovf),
		.out_side  (dv_side_out)
	);

	// ---------------- output stage: clamp step, update weight ----------------
	logic [W-1:0]        lim;
	logic                q_clamp;
	logic [W-1:0]        q_fin;
	logic signed [W+1:0] w_ext;
	logic signed [W+1:0] nw;
	logic                nw_hi;
	logic                nw_lo;

	// +max for a positive gradient, magnitude of min for a negative one
	assign lim     = {gneg_dv, {(W-1){~gneg_dv}}};
	assign q_clamp = nz_dv && (ovf || quot > lim);
	assign q_fin   = !nz_dv ? '0 : (q_clamp ? lim : quot);
	assign w_ext   = {{2{w_dv[W-1]}}, w_dv};
	assign nw      = gneg_dv ? w_ext + $signed({2'b00, q_fin})
	                         : w_ext - $signed({2'b00, q_fin});
	assign nw_hi   = !nw[W+1] && (nw[W:W-1] != 2'b00);
	assign nw_lo   = nw[W+1] && (nw[W:W-1] != 2'b11);

	logic signed [W-1:0] nw_q;
	logic [W-1:0]        nacc_q;
	logic                sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (nw_hi) begin
				nw_q <= {1'b0, {(W-1){1'b1}}};
			end else if (nw_lo) begin
				nw_q <= {1'b1, {(W-1){1'b0}}};
			end else begin
				nw_q <= nw[W-1:0];
			end
			nacc_q <= acc_dv;
			sat_q  <= sat_dv || q_clamp || nw_hi || nw_lo;
		end
	end

	assign out_valid       = out_valid_q;
	assign new_weight      = nw_q;
	assign new_accumulator = nacc_q;
	assign saturated       = sat_q;

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_weight)
			&& $stable(saturated))
		else $error("output changed while stalled");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !en |=> vld_s1 && $stable(num_s1))
		else $error("stage 1 lost data in a stall");

	a_cfg_upd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && widx == REG_UPDATE_ACC |=> upd_q == $past(pwdata[0]))
		else $error("update_accumulator write not taken");

	a_keep_acc: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && en && !upd_q |=> acc_s2 == $past(acc_s1))
		else $error("accumulator changed with update disabled");
`endif

endmodule
